[hdl/rsnh_pkg.sv]
// Shared types, constants and state encodings for the ray/sphere nearest-hit block.
// No dependencies; used by every module in hdl/.
package rsnh_pkg;

	localparam int MAX_SPHERES = 64;
	localparam int IDX_W       = $clog2(MAX_SPHERES);
	localparam int CNT_W       = $clog2(MAX_SPHERES + 1);

	// input item opcodes
	localparam logic [1:0] OP_CLEAR = 2'd0;
	localparam logic [1:0] OP_LOAD  = 2'd1;
	localparam logic [1:0] OP_RAY   = 2'd2;

	// configuration register indexes
	localparam logic REG_MIN_RANGE = 1'b0;
	localparam logic REG_MAX_RANGE = 1'b1;

	// reset values of configuration registers
	localparam logic [30:0] MIN_RANGE_RST = 31'd1311;
	localparam logic [30:0] MAX_RANGE_RST = 31'd13107;

	// shift codes for partial products
	localparam logic [1:0] SH_0  = 2'd0;
	localparam logic [1:0] SH_20 = 2'd1;
	localparam logic [1:0] SH_21 = 2'd2;
	localparam logic [1:0] SH_40 = 2'd3;

	typedef struct packed {
		logic [31:0] cx;
		logic [31:0] cy;
		logic [31:0] cz;
		logic [30:0] rad;
	} sph_t;

	typedef struct packed {
		logic [31:0] ox;
		logic [31:0] oy;
		logic [31:0] oz;
		logic [15:0] dx;
		logic [15:0] dy;
		logic [15:0] dz;
		logic [30:0] limit;
	} ray_t;

	typedef struct packed {
		logic        done;
		logic        hit;
		logic [30:0] distance;
	} isect_res_t;

	typedef enum logic [2:0] {
		I_IDLE, I_DIFF, I_DOT, I_FWD, I_SQ, I_CHK, I_SQRT, I_HIT
	} isect_state_t;

	typedef enum logic [2:0] {
		T_IDLE, T_RD, T_ST, T_RUN, T_DONE
	} top_state_t;

endpackage

[hdl/rsnh_sphere_mem.sv]
// Sphere table: synchronous RAM, one write port, one registered read port.
// Depends on rsnh_pkg for the entry type and depth.
module rsnh_sphere_mem (
	input  logic                    clk,
	input  logic                    we,
	input  logic [rsnh_pkg::IDX_W-1:0] waddr,
	input  rsnh_pkg::sph_t          wdata,
	input  logic                    re,
	input  logic [rsnh_pkg::IDX_W-1:0] raddr,
	output rsnh_pkg::sph_t          rdata
);

	rsnh_pkg::sph_t mem_q [rsnh_pkg::MAX_SPHERES];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

[hdl/rsnh_isect.sv]
// Ray/sphere intersection unit: one shared 20x20 multiplier, an 82-bit accumulator
// and a bit-serial square root. Depends on rsnh_pkg.
module rsnh_isect (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  rsnh_pkg::sph_t       sph,
	input  rsnh_pkg::ray_t       ray,
	input  logic [30:0]          min_rng,
	output rsnh_pkg::isect_res_t res
);

	rsnh_pkg::isect_state_t state_q, state_d;

	rsnh_pkg::sph_t       sph_q;
	logic signed [32:0]   ex_q, ey_q, ez_q;
	logic signed [81:0]   acc_q;
	logic signed [37:0]   fwd_q;
	logic [2:0]           t_q;
	logic [1:0]           p_q;
	logic [79:0]          op_q, root_q, one_q;
	logic                 done_q, hit_q;
	logic [30:0]          dist_q;

	logic [32:0]          emag;
	logic                 esign;
	logic [16:0]          dmag;
	logic                 dsign;
	logic [39:0]          sqx;
	logic [19:0]          mul_a, mul_b;
	logic [39:0]          prod;
	logic [1:0]           sh;
	logic                 neg;
	logic [81:0]          term;
	logic signed [37:0]   mr38;
	logic signed [39:0]   mr40, lim40, hit_near, hit_far, hit_v;
	logic [79:0]          trial;
	logic                 fwd_miss, dot_last, sq_last;

	assign mr38  = $signed({7'b0, min_rng});
	assign mr40  = $signed({9'b0, min_rng});
	assign lim40 = $signed({9'b0, ray.limit});

	// operand selection for the dot product terms
	always_comb begin
		emag  = '0;
		esign = 1'b0;
		dmag  = '0;
		dsign = 1'b0;
		case (t_q)
			3'd0: begin
				esign = ex_q[32];
				emag  = ex_q[32] ? 33'(-ex_q) : 33'(ex_q);
				dsign = ray.dx[15];
				dmag  = ray.dx[15] ? 17'(-$signed({ray.dx[15], ray.dx})) : {1'b0, ray.dx};
			end
			3'd1: begin
				esign = ey_q[32];
				emag  = ey_q[32] ? 33'(-ey_q) : 33'(ey_q);
				dsign = ray.dy[15];
				dmag  = ray.dy[15] ? 17'(-$signed({ray.dy[15], ray.dy})) : {1'b0, ray.dy};
			end
			default: begin
				esign = ez_q[32];
				emag  = ez_q[32] ? 33'(-ez_q) : 33'(ez_q);
				dsign = ray.dz[15];
				dmag  = ray.dz[15] ? 17'(-$signed({ray.dz[15], ray.dz})) : {1'b0, ray.dz};
			end
		endcase
	end

	// value to square: radius, forward projection, then the offset components
	always_comb begin
		case (t_q)
			3'd0:    sqx = {9'b0, sph_q.rad};
			3'd1:    sqx = {2'b0, fwd_q};
			3'd2:    sqx = ex_q[32] ? {7'b0, 33'(-ex_q)} : {7'b0, 33'(ex_q)};
			3'd3:    sqx = ey_q[32] ? {7'b0, 33'(-ey_q)} : {7'b0, 33'(ey_q)};
			default: sqx = ez_q[32] ? {7'b0, 33'(-ez_q)} : {7'b0, 33'(ez_q)};
		endcase
	end

	// multiplier operands and partial product placement
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		sh    = rsnh_pkg::SH_0;
		neg   = 1'b0;
		if (state_q == rsnh_pkg::I_DOT) begin
			mul_a = p_q[0] ? {7'b0, emag[32:20]} : emag[19:0];
			mul_b = {3'b0, dmag};
			sh    = p_q[0] ? rsnh_pkg::SH_20 : rsnh_pkg::SH_0;
			neg   = esign ^ dsign;
		end else begin
			neg = (t_q >= 3'd2);
			case (p_q)
				2'd0: begin
					mul_a = sqx[19:0];
					mul_b = sqx[19:0];
					sh    = rsnh_pkg::SH_0;
				end
				2'd1: begin
					mul_a = sqx[19:0];
					mul_b = sqx[39:20];
					sh    = rsnh_pkg::SH_21;
				end
				default: begin
					mul_a = sqx[39:20];
					mul_b = sqx[39:20];
					sh    = rsnh_pkg::SH_40;
				end
			endcase
		end
	end

	assign prod = mul_a * mul_b;

	always_comb begin
		case (sh)
			rsnh_pkg::SH_0:  term = {42'b0, prod};
			rsnh_pkg::SH_20: term = {22'b0, prod, 20'b0};
			rsnh_pkg::SH_21: term = {21'b0, prod, 21'b0};
			default:         term = {2'b0, prod, 40'b0};
		endcase
	end

	assign dot_last = (t_q == 3'd2) && (p_q == 2'd1);
	assign sq_last  = (t_q == 3'd4) && (p_q == 2'd2);
	assign fwd_miss = $signed(acc_q[51:14]) < mr38;
	assign trial    = root_q + one_q;

	// near root, or far root when the near one falls below min range
	assign hit_near = $signed({{2{fwd_q[37]}}, fwd_q}) - $signed({2'b0, root_q[37:0]});
	assign hit_far  = $signed({{2{fwd_q[37]}}, fwd_q}) + $signed({2'b0, root_q[37:0]});
	assign hit_v    = (hit_near < mr40) ? hit_far : hit_near;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			rsnh_pkg::I_IDLE: if (start) state_d = rsnh_pkg::I_DIFF;
			rsnh_pkg::I_DIFF: state_d = rsnh_pkg::I_DOT;
			rsnh_pkg::I_DOT:  if (dot_last) state_d = rsnh_pkg::I_FWD;
			rsnh_pkg::I_FWD:  state_d = fwd_miss ? rsnh_pkg::I_IDLE : rsnh_pkg::I_SQ;
			rsnh_pkg::I_SQ:   if (sq_last) state_d = rsnh_pkg::I_CHK;
			rsnh_pkg::I_CHK:  state_d = acc_q[81] ? rsnh_pkg::I_IDLE : rsnh_pkg::I_SQRT;
			rsnh_pkg::I_SQRT: if (one_q == 80'd1) state_d = rsnh_pkg::I_HIT;
			rsnh_pkg::I_HIT:  state_d = rsnh_pkg::I_IDLE;
			default:          state_d = rsnh_pkg::I_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rsnh_pkg::I_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= ((state_q == rsnh_pkg::I_FWD) && fwd_miss)
				|| ((state_q == rsnh_pkg::I_CHK) && acc_q[81])
				|| (state_q == rsnh_pkg::I_HIT);
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		case (state_q)
			rsnh_pkg::I_IDLE: begin
				if (start) sph_q <= sph;
			end
			rsnh_pkg::I_DIFF: begin
				ex_q  <= $signed({sph_q.cx[31], sph_q.cx}) - $signed({ray.ox[31], ray.ox});
				ey_q  <= $signed({sph_q.cy[31], sph_q.cy}) - $signed({ray.oy[31], ray.oy});
				ez_q  <= $signed({sph_q.cz[31], sph_q.cz}) - $signed({ray.oz[31], ray.oz});
				acc_q <= '0;
				t_q   <= '0;
				p_q   <= '0;
			end
			rsnh_pkg::I_DOT: begin
				acc_q <= neg ? acc_q - $signed(term) : acc_q + $signed(term);
				if (p_q == 2'd1) begin
					p_q <= '0;
					t_q <= t_q + 3'd1;
				end else begin
					p_q <= 2'd1;
				end
			end
			rsnh_pkg::I_FWD: begin
				fwd_q  <= $signed(acc_q[51:14]);
				acc_q  <= '0;
				t_q    <= '0;
				p_q    <= '0;
				hit_q  <= 1'b0;
				dist_q <= ray.limit;
			end
			rsnh_pkg::I_SQ: begin
				acc_q <= neg ? acc_q - $signed(term) : acc_q + $signed(term);
				if (p_q == 2'd2) begin
					p_q <= '0;
					t_q <= t_q + 3'd1;
				end else begin
					p_q <= p_q + 2'd1;
				end
			end
			rsnh_pkg::I_CHK: begin
				op_q   <= acc_q[79:0];
				root_q <= '0;
				one_q  <= 80'd1 << 78;
			end
			rsnh_pkg::I_SQRT: begin
				// one result bit per cycle
				if (op_q >= trial) begin
					op_q   <= op_q - trial;
					root_q <= (root_q >> 1) + one_q;
				end else begin
					root_q <= root_q >> 1;
				end
				one_q <= one_q >> 2;
			end
			rsnh_pkg::I_HIT: begin
				hit_q  <= !(hit_v < mr40) && !(hit_v > lim40);
				dist_q <= hit_v[30:0];
			end
			default: ;
		endcase
	end

	assign res.done     = done_q;
	assign res.hit      = hit_q & done_q;
	assign res.distance = dist_q;

endmodule

[hdl/ray_sphere_nearest_hit_top.sv]
// Each ray is tested against the N stored spheres in turn, and its result is registered after the
// last one; a sphere is dropped early if it fails the forward test or has no real root, before the
// bit-serial square root. A stalled result holds the next ray's result in T_DONE until it leaves.
// Throughput: clear and load items are taken one per cycle while idle; one ray at a time, the next item
// is not taken until the ray's result is registered.
// Reset (arst_n, asynchronous): empties the table, restores ranges and running minimum.
module ray_sphere_nearest_hit_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  op,
	input  logic [31:0] point_x,
	input  logic [31:0] point_y,
	input  logic [31:0] point_z,
	input  logic [15:0] dir_x,
	input  logic [15:0] dir_y,
	input  logic [15:0] dir_z,
	input  logic [30:0] radius,
	input  logic [30:0] range_limit,
	input  logic        last_ray,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [30:0] hit_distance,
	output logic        hit_flag,
	output logic [30:0] sensor_range,
	output logic        sensor_range_valid,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [30:0] cfg_data
);

	rsnh_pkg::top_state_t state_q, state_d;

	logic [30:0]                 min_rng_q, max_range_q;
	logic [rsnh_pkg::CNT_W-1:0]  count_q, k_q;
	logic [31:0]                 rmin_q;
	rsnh_pkg::ray_t              ray_q;
	logic                        last_q;
	logic [30:0]                 best_q;
	logic                        found_q;
	logic                        out_valid_q;

	logic                        accept, load_ok, out_free, k_last;
	rsnh_pkg::sph_t              wdata, rdata;
	rsnh_pkg::isect_res_t        ires;
	logic [31:0]                 new_min, sr_lo, sr;

	assign cfg_ready = 1'b1;
	assign accept    = in_valid && !in_stall;
	assign load_ok   = (radius != 31'd0)
		&& (count_q < rsnh_pkg::CNT_W'(rsnh_pkg::MAX_SPHERES));
	assign out_free  = !out_valid_q || !out_stall;
	assign k_last    = (k_q + rsnh_pkg::CNT_W'(1)) == count_q;

	assign wdata.cx  = point_x;
	assign wdata.cy  = point_y;
	assign wdata.cz  = point_z;
	assign wdata.rad = radius;

	rsnh_sphere_mem u_mem (
		.clk   (clk),
		.we    (accept && (op == rsnh_pkg::OP_LOAD) && load_ok),
		.waddr (count_q[rsnh_pkg::IDX_W-1:0]),
		.wdata (wdata),
		.re    (state_q == rsnh_pkg::T_RD),
		.raddr (k_q[rsnh_pkg::IDX_W-1:0]),
		.rdata (rdata)
	);

	rsnh_isect u_isect (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (state_q == rsnh_pkg::T_ST),
		.sph     (rdata),
		.ray     (ray_q),
		.min_rng (min_rng_q),
		.res     (ires)
	);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			rsnh_pkg::T_IDLE: begin
				if (accept && (op == rsnh_pkg::OP_RAY)) begin
					state_d = (count_q == '0) ? rsnh_pkg::T_DONE : rsnh_pkg::T_RD;
				end
			end
			rsnh_pkg::T_RD:   state_d = rsnh_pkg::T_ST;
			rsnh_pkg::T_ST:   state_d = rsnh_pkg::T_RUN;
			rsnh_pkg::T_RUN: begin
				if (ires.done) state_d = k_last ? rsnh_pkg::T_DONE : rsnh_pkg::T_RD;
			end
			rsnh_pkg::T_DONE: if (out_free) state_d = rsnh_pkg::T_IDLE;
			default:          state_d = rsnh_pkg::T_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		in_stall = (state_q != rsnh_pkg::T_IDLE);
	end

	// running minimum and clamp for the sensor range
	assign new_min = ({1'b0, best_q} < rmin_q) ? {1'b0, best_q} : rmin_q;
	assign sr_lo   = (new_min < {1'b0, min_rng_q}) ? {1'b0, min_rng_q} : new_min;
	assign sr      = (sr_lo > {1'b0, max_range_q}) ? {1'b0, max_range_q} : sr_lo;

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= rsnh_pkg::T_IDLE;
			min_rng_q   <= rsnh_pkg::MIN_RANGE_RST;
			max_range_q <= rsnh_pkg::MAX_RANGE_RST;
			count_q     <= '0;
			rmin_q      <= '1;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					rsnh_pkg::REG_MIN_RANGE: min_rng_q <= cfg_data;
					rsnh_pkg::REG_MAX_RANGE: max_range_q <= cfg_data;
					default: ;
				endcase
			end
			if (accept && (op == rsnh_pkg::OP_CLEAR)) begin
				count_q <= '0;
			end else if (accept && (op == rsnh_pkg::OP_LOAD) && load_ok) begin
				count_q <= count_q + rsnh_pkg::CNT_W'(1);
			end
			if ((state_q == rsnh_pkg::T_DONE) && out_free) begin
				out_valid_q <= 1'b1;
				rmin_q      <= last_q ? '1 : new_min;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// ray item and per-ray best hit
	always_ff @(posedge clk) begin
		if (accept && (op == rsnh_pkg::OP_RAY)) begin
			ray_q.ox    <= point_x;
			ray_q.oy    <= point_y;
			ray_q.oz    <= point_z;
			ray_q.dx    <= dir_x;
			ray_q.dy    <= dir_y;
			ray_q.dz    <= dir_z;
			ray_q.limit <= range_limit;
			last_q      <= last_ray;
			best_q      <= range_limit;
			found_q     <= 1'b0;
			k_q         <= '0;
		end
		if ((state_q == rsnh_pkg::T_RUN) && ires.done) begin
			k_q <= k_q + rsnh_pkg::CNT_W'(1);
			if (ires.hit) begin
				found_q <= 1'b1;
				if (ires.distance < best_q) best_q <= ires.distance;
			end
		end
		// result item register
		if ((state_q == rsnh_pkg::T_DONE) && out_free) begin
			hit_distance       <= best_q;
			hit_flag           <= found_q;
			sensor_range       <= last_q ? sr[30:0] : 31'd0;
			sensor_range_valid <= last_q;
		end
	end

	assign out_valid = out_valid_q;

endmodule
